>>> design/fbl_pkg.sv
// Shared types, constants and tables for the four-bar linkage solver.
// No dependencies; every other file of the block refers to it by scoped names.
package fbl_pkg;

    // CORDIC depth and rotation-mode start value (gain-compensated 1.0 in Q2.30)
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_START_X = 34'sd652032874;

    // Width of the exact quadratic coefficients and of their normalized form
    localparam int COEF_W = 56;
    localparam int NORM_W = 31;
    localparam int KW     = 38;

    // Status codes
    localparam logic [1:0] STATUS_SOLVED      = 2'd0;
    localparam logic [1:0] STATUS_NO_ASSEMBLY = 2'd1;
    localparam logic [1:0] STATUS_DEGENERATE  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_GROUND  = 3'd0;
    localparam logic [2:0] CFG_CRANK   = 3'd1;
    localparam logic [2:0] CFG_COUPLER = 3'd2;
    localparam logic [2:0] CFG_ROCKER  = 3'd3;
    localparam logic [2:0] CFG_BRANCH  = 3'd4;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic signed [KW-1:0]     kcoef_t;

    // Link lengths as held in the configuration registers
    typedef struct packed {
        logic [15:0] ground;
        logic [15:0] crank;
        logic [15:0] coupler;
        logic [15:0] rocker;
    } len_set_t;

    // Length-only factors of the six coefficients (co / si / constant parts)
    typedef struct packed {
        kcoef_t a1;
        kcoef_t a0;
        kcoef_t b;
        kcoef_t c0;
        kcoef_t c1;
        kcoef_t d1;
        kcoef_t d0;
        kcoef_t e;
        kcoef_t f0;
        kcoef_t f1;
    } link_k_t;

    // One half-angle quadratic p t^2 + q t + r
    typedef struct packed {
        coef_t p;
        coef_t q;
        coef_t r;
    } quad_t;

    // Result of one quadratic solve
    typedef struct packed {
        logic [15:0] angle;
        logic        no_asm;
        logic        degen;
    } solve_res_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] atan_tab(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/fbl_cos_sin.sv
// Pipelined rotation CORDIC: cos and sin in Q1.15 of a 32-bit-turn angle.
// Uses fbl_pkg (CORDIC depth, start value, arctangent table).
module fbl_cos_sin (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [31:0]        turn,
    output logic               out_vld,
    output logic signed [16:0] co,
    output logic signed [16:0] si
);

    localparam int N = fbl_pkg::CORDIC_STEPS;
    localparam logic signed [33:0] QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] HALF    = 34'sd2147483648;

    logic signed [33:0] z_in;
    logic signed [33:0] z_fold;
    logic               flip_in;

    logic signed [33:0] x_reg [0:N];
    logic signed [33:0] y_reg [0:N];
    logic signed [33:0] z_reg [0:N];
    logic [N:0]         flip_reg;
    logic [N:0]         vld_reg;

    logic signed [33:0] x_next [1:N];
    logic signed [33:0] y_next [1:N];
    logic signed [33:0] z_next [1:N];

    logic signed [33:0] xr;
    logic signed [33:0] yr;
    logic signed [16:0] co_next;
    logic signed [16:0] si_next;
    logic signed [16:0] co_reg;
    logic signed [16:0] si_reg;
    logic               out_vld_reg;

    // fold into [-quarter, quarter] turn
    always_comb
    begin
        z_in    = 34'(signed'(turn));
        flip_in = (z_in > QUARTER) || (z_in < -QUARTER);
        if (!flip_in)
            z_fold = z_in;
        else if (z_in > 0)
            z_fold = z_in - HALF;
        else
            z_fold = z_in + HALF;
    end

    // one micro-rotation per stage
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (z_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - signed'(34'(fbl_pkg::atan_tab(i)));
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + signed'(34'(fbl_pkg::atan_tab(i)));
            end
        end
    end

    // round to Q1.15 and undo the fold
    always_comb
    begin
        xr = (x_reg[N] + 34'sd16384) >>> 15;
        yr = (y_reg[N] + 34'sd16384) >>> 15;
        co_next = flip_reg[N] ? 17'(-xr) : 17'(xr);
        si_next = flip_reg[N] ? 17'(-yr) : 17'(yr);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[N-1:0], in_vld};
            out_vld_reg <= vld_reg[N];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= fbl_pkg::CORDIC_START_X;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_in;
            for (int i = 0; i < N; i++)
            begin
                x_reg[i+1]    <= x_next[i+1];
                y_reg[i+1]    <= y_next[i+1];
                z_reg[i+1]    <= z_next[i+1];
                flip_reg[i+1] <= flip_reg[i];
            end
            co_reg <= co_next;
            si_reg <= si_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign co      = co_reg;
    assign si      = si_reg;

endmodule

>>> design/fbl_coef.sv
// Builds the rocker (A,B,C) and coupler (D,E,F) half-angle quadratics.
// Uses fbl_pkg (length set, link factors, quadratic types).
module fbl_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  fbl_pkg::len_set_t  lens,
    input  logic               in_vld,
    input  logic signed [16:0] co,
    input  logic signed [16:0] si,
    output logic               out_vld,
    output fbl_pkg::quad_t     rocker_q,
    output fbl_pkg::quad_t     coupler_q
);

    localparam int KW = fbl_pkg::KW;
    localparam int CW = fbl_pkg::COEF_W;

    // length products, refreshed every cycle from the config registers
    logic [31:0] aa_reg, bb_reg, cc_reg, dd_reg;
    logic [31:0] ab_reg, ac_reg, ad_reg, bd_reg, cd_reg;
    logic signed [KW-1:0] s_aa, s_bb, s_cc, s_dd, s_ab, s_ac, s_ad, s_bd, s_cd;
    logic signed [KW-1:0] sq1, sq2;
    fbl_pkg::link_k_t k_next;
    fbl_pkg::link_k_t k_reg;

    fbl_pkg::coef_t pa1_reg, pb_reg, pc1_reg, pd1_reg, pe_reg, pf1_reg;
    fbl_pkg::quad_t rq_reg, cq_reg;
    logic [1:0]     vld_reg;

    always_ff @(posedge clk)
    begin
        aa_reg <= 32'(lens.crank)   * 32'(lens.crank);
        bb_reg <= 32'(lens.coupler) * 32'(lens.coupler);
        cc_reg <= 32'(lens.rocker)  * 32'(lens.rocker);
        dd_reg <= 32'(lens.ground)  * 32'(lens.ground);
        ab_reg <= 32'(lens.crank)   * 32'(lens.coupler);
        ac_reg <= 32'(lens.crank)   * 32'(lens.rocker);
        ad_reg <= 32'(lens.crank)   * 32'(lens.ground);
        bd_reg <= 32'(lens.coupler) * 32'(lens.ground);
        cd_reg <= 32'(lens.rocker)  * 32'(lens.ground);
        k_reg  <= k_next;
    end

    // length-only factors
    always_comb
    begin
        s_aa = signed'(KW'(aa_reg));
        s_bb = signed'(KW'(bb_reg));
        s_cc = signed'(KW'(cc_reg));
        s_dd = signed'(KW'(dd_reg));
        s_ab = signed'(KW'(ab_reg));
        s_ac = signed'(KW'(ac_reg));
        s_ad = signed'(KW'(ad_reg));
        s_bd = signed'(KW'(bd_reg));
        s_cd = signed'(KW'(cd_reg));
        sq1  = s_aa - s_bb + s_cc + s_dd;
        sq2  = s_cc - s_dd - s_aa - s_bb;
        k_next.a1 = (s_ac - s_ad) <<< 1;
        k_next.a0 = sq1 - (s_cd <<< 1);
        k_next.b  = s_ac <<< 2;
        k_next.c0 = sq1 + (s_cd <<< 1);
        k_next.c1 = (s_ad + s_ac) <<< 1;
        k_next.d1 = (s_ab + s_ad) <<< 1;
        k_next.d0 = sq2 - (s_bd <<< 1);
        k_next.e  = s_ab <<< 2;
        k_next.f0 = sq2 + (s_bd <<< 1);
        k_next.f1 = (s_ad - s_ab) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], in_vld};
    end

    // stage 1: products with cos / sin; stage 2: sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa1_reg <= CW'(k_reg.a1) * CW'(co);
            pb_reg  <= CW'(k_reg.b)  * CW'(si);
            pc1_reg <= CW'(k_reg.c1) * CW'(co);
            pd1_reg <= CW'(k_reg.d1) * CW'(co);
            pe_reg  <= CW'(k_reg.e)  * CW'(si);
            pf1_reg <= CW'(k_reg.f1) * CW'(co);

            rq_reg.p <= pa1_reg + (CW'(k_reg.a0) <<< 15);
            rq_reg.q <= -pb_reg;
            rq_reg.r <= (CW'(k_reg.c0) <<< 15) - pc1_reg;
            cq_reg.p <= pd1_reg + (CW'(k_reg.d0) <<< 15);
            cq_reg.q <= -pe_reg;
            cq_reg.r <= (CW'(k_reg.f0) <<< 15) + pf1_reg;
        end
    end

    assign out_vld   = vld_reg[1];
    assign rocker_q  = rq_reg;
    assign coupler_q = cq_reg;

endmodule

>>> design/fbl_solve.sv
// Pipelined solver of p t^2 + q t + r = 0 with angle = 2 atan(t):
// normalize, discriminant, digit-by-digit square root, vectoring CORDIC, round.
// Uses fbl_pkg (coefficient types, arctangent table, result struct).
module fbl_solve #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                plus,
    input  logic                in_vld,
    input  fbl_pkg::quad_t      quad,
    output logic                out_vld,
    output fbl_pkg::solve_res_t res
);

    localparam int CW = fbl_pkg::COEF_W;
    localparam int NW = fbl_pkg::NORM_W;
    localparam int N  = fbl_pkg::CORDIC_STEPS;
    localparam int SQ = 32;
    localparam int SH = 32 - ANGLE_BITS;
    localparam logic [32:0] ANG_MASK = (33'd1 << ANGLE_BITS) - 33'd1;
    localparam logic [32:0] DEG_ANG  = 33'd1 << (ANGLE_BITS - 1);
    // total stages: 4 front, square root, numerator, CORDIC, output
    localparam int LAT = 4 + SQ + 1 + N + 1;

    logic [LAT-1:0] vld_reg;

    // normalize shift
    logic [CW-1:0] mag_or;
    logic [5:0]    msb;
    logic [5:0]    s_next;
    fbl_pkg::coef_t p1_reg, q1_reg, r1_reg;
    logic [5:0]     s1_reg;
    fbl_pkg::norm_t p2_reg, q2_reg, r2_reg;
    fbl_pkg::norm_t p3_reg, q3_reg;
    logic signed [61:0] qq3_reg, pr3_reg;
    logic signed [63:0] disc;

    // square root stages
    logic [33:0] rem_reg  [0:SQ];
    logic [31:0] root_reg [0:SQ];
    logic [63:0] v_reg    [0:SQ];
    fbl_pkg::norm_t p_sq_reg [0:SQ];
    fbl_pkg::norm_t q_sq_reg [0:SQ];
    logic [SQ:0] neg_sq_reg;
    logic [SQ:0] pz_sq_reg;
    logic [35:0] rem2   [0:SQ-1];
    logic [35:0] trial  [0:SQ-1];
    logic [33:0] rem_next  [1:SQ];
    logic [31:0] root_next [1:SQ];

    // numerator / denominator
    logic signed [33:0] num;
    logic signed [33:0] den;

    // vectoring stages
    logic signed [35:0] vx_reg [0:N];
    logic signed [35:0] vy_reg [0:N];
    logic signed [32:0] vz_reg [0:N];
    logic [N:0]         neg_v_reg;
    logic [N:0]         pz_v_reg;
    logic signed [35:0] vx_next [1:N];
    logic signed [35:0] vy_next [1:N];
    logic signed [32:0] vz_next [1:N];

    // output rounding
    logic signed [34:0] v2;
    logic signed [34:0] vr;
    logic [31:0]        ang32;
    fbl_pkg::solve_res_t res_next;
    fbl_pkg::solve_res_t res_reg;

    // leading one of the largest magnitude
    always_comb
    begin
        mag_or = (quad.p[CW-1] ? CW'(-quad.p) : CW'(quad.p))
               | (quad.q[CW-1] ? CW'(-quad.q) : CW'(quad.q))
               | (quad.r[CW-1] ? CW'(-quad.r) : CW'(quad.r));
        msb = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (mag_or[i])
                msb = 6'(i);
        end
        s_next = (msb >= 6'd30) ? (msb - 6'd29) : 6'd0;
    end

    assign disc = 64'(qq3_reg) - (64'(pr3_reg) <<< 2);

    // square root: one result bit per stage
    always_comb
    begin
        for (int i = 0; i < SQ; i++)
        begin
            rem2[i]  = {rem_reg[i], v_reg[i][63:62]};
            trial[i] = 36'({root_reg[i], 2'b01});
            if (rem2[i] >= trial[i])
            begin
                rem_next[i+1]  = 34'(rem2[i] - trial[i]);
                root_next[i+1] = {root_reg[i][30:0], 1'b1};
            end
            else
            begin
                rem_next[i+1]  = rem2[i][33:0];
                root_next[i+1] = {root_reg[i][30:0], 1'b0};
            end
        end
    end

    // pick the root, make the denominator positive
    always_comb
    begin
        if (plus)
            num = -34'(q_sq_reg[SQ]) + signed'(34'(root_reg[SQ]));
        else
            num = -34'(q_sq_reg[SQ]) - signed'(34'(root_reg[SQ]));
        den = 34'(p_sq_reg[SQ]) <<< 1;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
    end

    // vectoring micro-rotations
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (vy_reg[i] > 0)
            begin
                vx_next[i+1] = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] - (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] + signed'(33'(fbl_pkg::atan_tab(i)));
            end
            else
            begin
                vx_next[i+1] = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] + (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] - signed'(33'(fbl_pkg::atan_tab(i)));
            end
        end
    end

    // double, round to the angle width, wrap
    assign v2 = 35'(vz_reg[N]) <<< 1;

    generate
        if (SH > 0)
        begin : g_round
            assign vr = (v2 + (35'sd1 <<< (SH - 1))) >>> SH;
        end
        else
        begin : g_exact
            assign vr = v2;
        end
    endgenerate

    always_comb
    begin
        ang32           = vr[31:0] & ANG_MASK[31:0];
        res_next.no_asm = neg_v_reg[N];
        res_next.degen  = pz_v_reg[N];
        res_next.angle  = pz_v_reg[N] ? DEG_ANG[15:0] : ang32[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // front: normalize, products, discriminant
            p1_reg  <= quad.p;
            q1_reg  <= quad.q;
            r1_reg  <= quad.r;
            s1_reg  <= s_next;
            p2_reg  <= NW'(p1_reg >>> s1_reg);
            q2_reg  <= NW'(q1_reg >>> s1_reg);
            r2_reg  <= NW'(r1_reg >>> s1_reg);
            qq3_reg <= 62'(q2_reg) * 62'(q2_reg);
            pr3_reg <= 62'(p2_reg) * 62'(r2_reg);
            p3_reg  <= p2_reg;
            q3_reg  <= q2_reg;

            rem_reg[0]    <= '0;
            root_reg[0]   <= '0;
            v_reg[0]      <= disc;
            p_sq_reg[0]   <= p3_reg;
            q_sq_reg[0]   <= q3_reg;
            neg_sq_reg[0] <= disc[63];
            pz_sq_reg[0]  <= (p3_reg == '0);
            for (int i = 0; i < SQ; i++)
            begin
                rem_reg[i+1]    <= rem_next[i+1];
                root_reg[i+1]   <= root_next[i+1];
                v_reg[i+1]      <= {v_reg[i][61:0], 2'b00};
                p_sq_reg[i+1]   <= p_sq_reg[i];
                q_sq_reg[i+1]   <= q_sq_reg[i];
                neg_sq_reg[i+1] <= neg_sq_reg[i];
                pz_sq_reg[i+1]  <= pz_sq_reg[i];
            end

            vx_reg[0]    <= 36'(den);
            vy_reg[0]    <= 36'(num);
            vz_reg[0]    <= '0;
            neg_v_reg[0] <= neg_sq_reg[SQ];
            pz_v_reg[0]  <= pz_sq_reg[SQ];
            for (int i = 0; i < N; i++)
            begin
                vx_reg[i+1]    <= vx_next[i+1];
                vy_reg[i+1]    <= vy_next[i+1];
                vz_reg[i+1]    <= vz_next[i+1];
                neg_v_reg[i+1] <= neg_v_reg[i];
                pz_v_reg[i+1]  <= pz_v_reg[i];
            end

            res_reg <= res_next;
        end
    end

    assign out_vld = vld_reg[LAT-1];
    assign res     = res_reg;

endmodule

>>> design/four_bar_linkage_solver_unit.sv
// Four-bar linkage position solver: crank angle in, coupler and rocker angles out.
// Path: cos/sin CORDIC, coefficient stages, the two solvers, then 1 output register.
// Throughput one item per cycle; the whole pipeline holds while the output register is full
// and not taken. Config registers reset to lengths 256 and the open branch.
// In the datapath, reset clears only the valid bits and the output valid; no clearing pass.
// Uses fbl_pkg, fbl_cos_sin, fbl_coef and two fbl_solve instances.
module four_bar_linkage_solver_unit #(
    parameter int ANGLE_BITS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] crank_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] coupler_angle,
    output logic signed [15:0] rocker_angle,
    output logic [1:0]         status
);

    localparam logic [15:0] LEN_MASK = (LENGTH_BITS >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << LENGTH_BITS) - 32'd1);
    localparam logic [32:0] ANG_MASK = (33'd1 << ANGLE_BITS) - 33'd1;
    localparam logic [32:0] DEG_ANG  = 33'd1 << (ANGLE_BITS - 1);

    fbl_pkg::len_set_t lens_reg;
    logic              branch_reg;
    logic              en;
    logic [63:0]       turn64;

    logic               cs_vld;
    logic signed [16:0] co;
    logic signed [16:0] si;
    logic               cf_vld;
    fbl_pkg::quad_t     rocker_q;
    fbl_pkg::quad_t     coupler_q;
    logic               r_vld;
    logic               c_vld;
    fbl_pkg::solve_res_t r_res;
    fbl_pkg::solve_res_t c_res;

    logic               out_valid_reg;
    logic signed [15:0] coupler_reg;
    logic signed [15:0] rocker_reg;
    logic [1:0]         status_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lens_reg.ground  <= 16'd256;
            lens_reg.crank   <= 16'd256;
            lens_reg.coupler <= 16'd256;
            lens_reg.rocker  <= 16'd256;
            branch_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fbl_pkg::CFG_GROUND:  lens_reg.ground  <= cfg_data & LEN_MASK;
                fbl_pkg::CFG_CRANK:   lens_reg.crank   <= cfg_data & LEN_MASK;
                fbl_pkg::CFG_COUPLER: lens_reg.coupler <= cfg_data & LEN_MASK;
                fbl_pkg::CFG_ROCKER:  lens_reg.rocker  <= cfg_data & LEN_MASK;
                fbl_pkg::CFG_BRANCH:  branch_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // global advance: pipeline moves unless a result waits untaken
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // crank angle to a 32-bit turn
    assign turn64 = ({48'd0, crank_angle} & {31'd0, ANG_MASK}) << (32 - ANGLE_BITS);

    fbl_cos_sin u_cos_sin (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .turn    (turn64[31:0]),
        .out_vld (cs_vld),
        .co      (co),
        .si      (si)
    );

    fbl_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .lens      (lens_reg),
        .in_vld    (cs_vld),
        .co        (co),
        .si        (si),
        .out_vld   (cf_vld),
        .rocker_q  (rocker_q),
        .coupler_q (coupler_q)
    );

    fbl_solve #(.ANGLE_BITS(ANGLE_BITS)) u_solve_rocker (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .plus    (branch_reg),
        .in_vld  (cf_vld),
        .quad    (rocker_q),
        .out_vld (r_vld),
        .res     (r_res)
    );

    fbl_solve #(.ANGLE_BITS(ANGLE_BITS)) u_solve_coupler (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .plus    (branch_reg),
        .in_vld  (cf_vld),
        .quad    (coupler_q),
        .out_vld (c_vld),
        .res     (c_res)
    );

    // output register: merge the two statuses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r_vld & c_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r_res.no_asm || c_res.no_asm)
            begin
                coupler_reg <= '0;
                rocker_reg  <= '0;
                status_reg  <= fbl_pkg::STATUS_NO_ASSEMBLY;
            end
            else
            begin
                coupler_reg <= c_res.angle;
                rocker_reg  <= r_res.angle;
                status_reg  <= (r_res.degen || c_res.degen) ? fbl_pkg::STATUS_DEGENERATE
                                                            : fbl_pkg::STATUS_SOLVED;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign coupler_angle = coupler_reg;
    assign rocker_angle  = rocker_reg;
    assign status        = status_reg;

    // no-assembly results carry zero angles
    a_noasm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == fbl_pkg::STATUS_NO_ASSEMBLY)
        |-> (coupler_angle == '0 && rocker_angle == '0))
        else $error("no-assembly result with nonzero angle");

    // a degenerate result has at least one half-turn angle
    a_degen_half: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == fbl_pkg::STATUS_DEGENERATE)
        |-> (coupler_angle == DEG_ANG[15:0] || rocker_angle == DEG_ANG[15:0]))
        else $error("degenerate result without half-turn angle");

    // both solver lanes stay in step
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        r_vld == c_vld)
        else $error("solver lanes out of step");

endmodule

>>> tb/sv/fbl_linkage_checker.sv
// Checker for the four-bar linkage solver: follows the config writes, predicts the angles of
// every accepted crank angle and compares them with each accepted result, oldest first.
// Depends on fbl_pkg for the status codes and register indexes.
module fbl_linkage_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] crank_angle,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] coupler_angle,
    input  logic signed [15:0] rocker_angle,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint COEF_CAP     = 64'sd1073741824;

    // atan(2^-i), 2^32 per turn
    localparam longint ARC_STEP [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef struct {
        logic [15:0] coupler;
        logic [15:0] rocker;
        logic [1:0]  code;
    } pose_t;

    typedef struct {
        longint ground;
        longint crank;
        longint coupler;
        longint rocker;
        bit     crossed;
    } linkage_t;

    linkage_t links;
    pose_t    pose_q[$];

    // Rotation CORDIC: cos and sin of a 32-bit turn, Q1.15
    function automatic void crank_cos_sin(input logic [31:0] turn, output longint co,
                                          output longint si);
        longint z, x, y, nx, ny;
        bit flip;
        z = longint'(signed'(turn));
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > QUARTER_TURN || z < -QUARTER_TURN)
        begin
            z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
            flip = 1;
        end
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ARC_STEP[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ARC_STEP[i];
            end
            x = nx;
            y = ny;
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        co = flip ? -x : x;
        si = flip ? -y : y;
    endfunction

    // Vectoring CORDIC: atan(num/den), den > 0
    function automatic longint vector_atan(input longint num, input longint den);
        longint x, y, z, nx, ny;
        x = den;
        y = num;
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ARC_STEP[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ARC_STEP[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs_of(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Half-angle root of p t^2 + q t + r = 0, angle = 2 atan(t)
    function automatic logic [1:0] half_angle_root(input longint p, input longint q,
                                                   input longint r, input bit crossed,
                                                   output logic [15:0] ang);
        longint unsigned m, root;
        longint disc, num, den, v;
        int sh;
        m = abs_of(p);
        if (abs_of(q) > m) m = abs_of(q);
        if (abs_of(r) > m) m = abs_of(r);
        sh = 0;
        while ((m >> sh) >= COEF_CAP)
            sh++;
        p = p >>> sh;
        q = q >>> sh;
        r = r >>> sh;
        disc = q * q - 4 * p * r;
        ang = '0;
        if (disc < 0)
            return fbl_pkg::STATUS_NO_ASSEMBLY;
        if (p == 0)
        begin
            ang = 16'h8000;
            return fbl_pkg::STATUS_DEGENERATE;
        end
        root = floor_sqrt(disc);
        num = crossed ? -q + longint'(root) : -q - longint'(root);
        den = 2 * p;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        v = 2 * vector_atan(num, den);
        v = (v + 32768) >>> 16;
        ang = v[15:0];
        return fbl_pkg::STATUS_SOLVED;
    endfunction

    // Expected pose for one crank angle under the current link lengths
    function automatic pose_t linkage_pose(input logic [15:0] crank);
        longint a, b, c, d, co, si, sq1, sq2;
        longint qa, qb, qc, qd, qe, qf;
        logic [1:0] st3, st4;
        logic [15:0] th3, th4;
        pose_t res;
        a = links.crank;
        b = links.coupler;
        c = links.rocker;
        d = links.ground;
        crank_cos_sin({crank, 16'h0000}, co, si);
        sq1 = a * a - b * b + c * c + d * d;
        sq2 = c * c - d * d - a * a - b * b;
        qa = (2 * a * c - 2 * a * d) * co + (sq1 - 2 * c * d) * 32768;
        qb = -4 * a * c * si;
        qc = (sq1 + 2 * c * d) * 32768 - (2 * a * d + 2 * a * c) * co;
        qd = (2 * a * b + 2 * a * d) * co + (sq2 - 2 * b * d) * 32768;
        qe = -4 * a * b * si;
        qf = (sq2 + 2 * b * d) * 32768 + (2 * a * d - 2 * a * b) * co;
        st4 = half_angle_root(qa, qb, qc, links.crossed, th4);
        st3 = half_angle_root(qd, qe, qf, links.crossed, th3);
        if (st3 == fbl_pkg::STATUS_NO_ASSEMBLY || st4 == fbl_pkg::STATUS_NO_ASSEMBLY)
        begin
            res.coupler = '0;
            res.rocker = '0;
            res.code = fbl_pkg::STATUS_NO_ASSEMBLY;
        end
        else
        begin
            res.coupler = th3;
            res.rocker = th4;
            res.code = (st3 == fbl_pkg::STATUS_DEGENERATE || st4 == fbl_pkg::STATUS_DEGENERATE) ?
                       fbl_pkg::STATUS_DEGENERATE : fbl_pkg::STATUS_SOLVED;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        if (!rst_n)
        begin
            links.ground = 256;
            links.crank = 256;
            links.coupler = 256;
            links.rocker = 256;
            links.crossed = 0;
            pose_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // Register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fbl_pkg::CFG_GROUND:  links.ground = longint'(cfg_data);
                    fbl_pkg::CFG_CRANK:   links.crank = longint'(cfg_data);
                    fbl_pkg::CFG_COUPLER: links.coupler = longint'(cfg_data);
                    fbl_pkg::CFG_ROCKER:  links.rocker = longint'(cfg_data);
                    fbl_pkg::CFG_BRANCH:  links.crossed = cfg_data[0];
                    default: ;
                endcase
            end
            // New crank angle
            if (in_valid && in_ready)
                pose_q = {pose_q, linkage_pose(crank_angle)};
            // Result compare
            if (out_valid && out_ready)
            begin
                if (pose_q.size() == 0)
                begin
                    $error("result with nothing expected: coupler %0d rocker %0d status %0d",
                           coupler_angle, rocker_angle, status);
                    fail_count++;
                end
                else
                begin
                    want = pose_q.pop_front();
                    if (coupler_angle !== want.coupler)
                    begin
                        $error("coupler_angle expected %0d actual %0d",
                               $signed(want.coupler), coupler_angle);
                        fail_count++;
                    end
                    if (rocker_angle !== want.rocker)
                    begin
                        $error("rocker_angle expected %0d actual %0d",
                               $signed(want.rocker), rocker_angle);
                        fail_count++;
                    end
                    if (status !== want.code)
                    begin
                        $error("status expected %0d actual %0d", want.code, status);
                        fail_count++;
                    end
                end
            end
            pending = pose_q.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
// Top of the four-bar linkage solver testbench: clock, reset, config and crank-angle stimulus,
// receiver stalls, watchdog and verdict. Depends on fbl_pkg, the solver and fbl_linkage_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 103;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 85;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] crank_angle;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] coupler_angle;
    logic signed [15:0] rocker_angle;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;

    bit quiet;
    bit hold_req;
    int idle_cycles;

    four_bar_linkage_solver_unit u_top (.*);

    fbl_linkage_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Offer one crank angle and hold it until taken; valid stays high afterwards unless a random gap drops it
    task automatic send_angle(input logic [15:0] ang);
        in_valid <= 1'b1;
        crank_angle <= ang;
        do @(posedge clk); while (!in_ready);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_linkage(input logic [15:0] g, input logic [15:0] a,
                               input logic [15:0] b, input logic [15:0] c, input bit br);
        write_reg(fbl_pkg::CFG_GROUND, g);
        write_reg(fbl_pkg::CFG_CRANK, a);
        write_reg(fbl_pkg::CFG_COUPLER, b);
        write_reg(fbl_pkg::CFG_ROCKER, c);
        write_reg(fbl_pkg::CFG_BRANCH, {15'h0, br});
        // unused index, must be ignored
        write_reg(3'($urandom_range(5, 7)), 16'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("four_bar_linkage_solver_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] edge_angles [8];
        logic [15:0] g, a, b, c;
        edge_angles = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h0001,
                        16'hFFFF, 16'h2000};
        idle_cycles = 0;
        quiet = 0;
        hold_req = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        crank_angle = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset lengths: all links equal
        foreach (edge_angles[i])
            send_angle(edge_angles[i]);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin g = 16'd400;   a = 16'd100;   b = 16'd350;   c = 16'd300;   end
                1: begin g = 16'd400;   a = 16'd100;   b = 16'd350;   c = 16'd300;   end
                2: begin g = 16'd65535; a = 16'd1;     b = 16'd65535; c = 16'd65535; end
                3: begin g = 16'd1;     a = 16'd65535; b = 16'd1;     c = 16'd1;     end
                4: begin g = 16'd65535; a = 16'd65535; b = 16'd65535; c = 16'd65535; end
                5: begin g = 16'd1;     a = 16'd1;     b = 16'd1;     c = 16'd1;     end
                default:
                begin
                    g = 16'($urandom_range(1, 65535));
                    a = 16'($urandom_range(1, 65535));
                    b = 16'($urandom_range(1, 65535));
                    c = 16'($urandom_range(1, 65535));
                end
            endcase
            set_linkage(g, a, b, c, (ph == 1 || ph == 2) ? 1'b1 : ph[0]);
            if (ph == PHASES - 1)
                quiet = 1;
            if (ph < 2)
                foreach (edge_angles[i])
                    send_angle(edge_angles[i]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (ph == 0 && k == 10)
                    hold_req = 1;
                if (ph == 1 && k == 40)
                    drain_results();
                send_angle(16'($urandom));
            end
            drain_results();
        end

        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("four_bar_linkage_solver_unit regression: pass");
        else
            $display("four_bar_linkage_solver_unit regression: fail");
        $finish;
    end

endmodule
